[rtl/cmbp_pkg.sv]
// Package for the context match byte predictor.
// Holds the sizes and result kind codes; depends on nothing.
`default_nettype none
package cmbp_pkg;
  localparam int MAX_WINDOW    = 8192;
  localparam int CONTEXT_BYTES = 8;
  localparam int LEVELS        = CONTEXT_BYTES + 1;
  localparam int PROB_BITS     = 25;
  localparam int HIST_DEPTH    = MAX_WINDOW + CONTEXT_BYTES;
  localparam int ADDR_W        = $clog2(HIST_DEPTH);
  localparam int CNT_W         = 14;
  localparam int LV_W          = 4;
  localparam int SUM_W         = 41;
  localparam int DIV_W         = 56;
  localparam int DIVR_W        = 16;
  localparam int DIV_CNT_W     = 6;
  localparam int WIN_RESET     = 8000;

  localparam logic [1:0] KIND_FIRST = 2'd0;
  localparam logic [1:0] KIND_NEW   = 2'd1;
  localparam logic [1:0] KIND_REF   = 2'd2;
endpackage
`default_nettype wire

[rtl/context_match_byte_predictor_core.sv]
// Top level of the context match byte predictor: history scan and scoring.
// Depends on cmbp_pkg, cmbp_ram for the history and cmbp_div for the divisions.
//
// Channel   Direction  Signals
// in        input      in_valid, in_ready, byte_in
// out       output     out_valid, out_ready, kind, literal, probability
// cfg       input      cfg_valid, cfg_ready, window_length
//
// The first word skips the scan. A later word scans n + 8 history bytes (n the searched
// window), then runs one division per non-empty level, skips each empty level and ends
// with the final division. The scan reads one history byte a cycle.
// Reset clears the control state; unwritten history reads as zero by a fill count.
// A result waits in the output register while the next word is taken.
`default_nettype none
module context_match_byte_predictor_core import cmbp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  byte_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [1:0]  kind,
  output logic      [7:0]  literal,
  output logic      [25:0] probability,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [13:0] window_length
);
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_LEVEL = 6'b000100,
    S_DWAIT = 6'b001000,
    S_FWAIT = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t            state;
  logic [13:0]       win_len;
  logic [ADDR_W-1:0] head;
  logic [ADDR_W-1:0] fill;
  logic [7:0]        ctx [CONTEXT_BYTES];
  logic [7:0]        win [CONTEXT_BYTES];
  logic [7:0]        cur;
  logic [ADDR_W-1:0] n;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] back_iss;
  logic [ADDR_W-1:0] back_q;
  logic              rvld;
  logic [CNT_W-1:0]  cc [LEVELS];
  logic [CNT_W-1:0]  pc [LEVELS];
  logic [LV_W-1:0]   lv_i;
  logic [SUM_W-1:0]  sum;
  logic [LEVELS-1:0] weight;
  logic [1:0]        res_kind;
  logic [7:0]        res_lit;
  logic [25:0]       res_prob;

  logic [7:0]        rdata;
  logic [7:0]        rbyte;
  logic [LV_W-1:0]   lv;
  logic              run;
  logic [13:0]       win_sat;
  logic [ADDR_W-1:0] n_new;
  logic [ADDR_W:0]   start_sum;
  logic              we;
  logic              div_start;
  logic              div_done;
  logic [DIV_W-1:0]  dividend;
  logic [DIVR_W-1:0] divisor;
  logic [DIV_W-1:0]  quot;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign we        = (state == S_DONE) && (!out_valid || out_ready);

  always_comb begin
    win_sat   = (win_len > 14'(MAX_WINDOW)) ? 14'(MAX_WINDOW) : win_len;
    n_new     = (fill < ADDR_W'(win_sat)) ? fill : ADDR_W'(win_sat);
    start_sum = {1'b0, head} + (ADDR_W+1)'(HIST_DEPTH)
              - (ADDR_W+1)'(n_new) - (ADDR_W+1)'(CONTEXT_BYTES);
    if (start_sum >= (ADDR_W+1)'(HIST_DEPTH)) begin
      start_sum = start_sum - (ADDR_W+1)'(HIST_DEPTH);
    end
    rbyte = (back_q > fill) ? 8'd0 : rdata;
    lv    = '0;
    run   = 1'b1;
    for (int k = 0; k < CONTEXT_BYTES; k++) begin
      if (run && win[k] == ctx[k]) begin
        lv = lv + LV_W'(1);
      end else begin
        run = 1'b0;
      end
    end
  end

  always_comb begin
    div_start = 1'b0;
    dividend  = '0;
    divisor   = '0;
    if (state == S_LEVEL) begin
      if (lv_i == LV_W'(LEVELS)) begin
        div_start = (sum != '0);
        dividend  = DIV_W'(sum);
        divisor   = {weight, 7'd0};
      end else if (cc[lv_i] != '0) begin
        div_start = 1'b1;
        dividend  = DIV_W'(pc[lv_i]) << (6'(lv_i) + 6'd32);
        divisor   = DIVR_W'(cc[lv_i]);
      end
    end
  end

  cmbp_ram #(.WIDTH(8), .DEPTH(HIST_DEPTH)) u_hist (
    .clk   (clk),
    .we    (we),
    .waddr (head),
    .wdata (cur),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  cmbp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      win_len   <= 14'(WIN_RESET);
      head      <= '0;
      fill      <= '0;
      out_valid <= 1'b0;
      rvld      <= 1'b0;
      back_iss  <= '0;
      for (int k = 0; k < CONTEXT_BYTES; k++) begin
        ctx[k] <= 8'd0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        win_len <= window_length;
      end
      if (we) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur <= byte_in;
            if (fill == '0) begin
              res_kind <= KIND_FIRST;
              res_lit  <= byte_in;
              res_prob <= '0;
              state    <= S_DONE;
            end else begin
              n        <= n_new;
              rd_addr  <= start_sum[ADDR_W-1:0];
              back_iss <= n_new + ADDR_W'(CONTEXT_BYTES);
              rvld     <= 1'b0;
              for (int l = 0; l < LEVELS; l++) begin
                cc[l] <= '0;
                pc[l] <= '0;
              end
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (back_iss != '0) begin
            rd_addr  <= (rd_addr == ADDR_W'(HIST_DEPTH - 1)) ? '0 : rd_addr + ADDR_W'(1);
            back_iss <= back_iss - ADDR_W'(1);
            back_q   <= back_iss;
            rvld     <= 1'b1;
          end else begin
            rvld <= 1'b0;
          end
          if (rvld) begin
            win[0] <= rbyte;
            for (int k = 1; k < CONTEXT_BYTES; k++) begin
              win[k] <= win[k-1];
            end
            if (back_q <= n) begin
              cc[lv] <= cc[lv] + CNT_W'(1);
              if (rbyte == cur) begin
                pc[lv] <= pc[lv] + CNT_W'(1);
              end
            end
            if (back_q == ADDR_W'(1)) begin
              lv_i   <= '0;
              sum    <= '0;
              weight <= '0;
              state  <= S_LEVEL;
            end
          end
        end
        S_LEVEL: begin
          if (lv_i == LV_W'(LEVELS)) begin
            if (sum == '0) begin
              res_kind <= KIND_NEW;
              res_lit  <= cur;
              res_prob <= '0;
              state    <= S_DONE;
            end else begin
              state <= S_FWAIT;
            end
          end else if (cc[lv_i] != '0) begin
            state <= S_DWAIT;
          end else begin
            lv_i <= lv_i + LV_W'(1);
          end
        end
        S_DWAIT: begin
          if (div_done) begin
            sum    <= sum + quot[SUM_W-1:0];
            weight <= weight | (LEVELS'(1) << lv_i);
            lv_i   <= lv_i + LV_W'(1);
            state  <= S_LEVEL;
          end
        end
        S_FWAIT: begin
          if (div_done) begin
            res_kind <= KIND_REF;
            res_lit  <= 8'd0;
            res_prob <= quot[25:0];
            state    <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            kind        <= res_kind;
            literal     <= res_lit;
            probability <= res_prob;
            head        <= (head == ADDR_W'(HIST_DEPTH - 1)) ? '0 : head + ADDR_W'(1);
            if (fill != ADDR_W'(HIST_DEPTH)) begin
              fill <= fill + ADDR_W'(1);
            end
            ctx[0] <= cur;
            for (int k = 1; k < CONTEXT_BYTES; k++) begin
              ctx[k] <= ctx[k-1];
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= ADDR_W'(HIST_DEPTH) && head < ADDR_W'(HIST_DEPTH))
    else $error("history fill or head out of range");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DWAIT || state == S_FWAIT))
    else $error("divider finished outside a wait state");

  a_scan_back: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && rvld) |-> (back_q != '0 && back_q <= n + ADDR_W'(CONTEXT_BYTES)))
    else $error("scan read outside the searched window");

  a_first_literal: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && fill == '0) |=> (state == S_DONE && res_kind == KIND_FIRST))
    else $error("first word not passed as a literal");
endmodule
`default_nettype wire

[rtl/cmbp_ram.sv]
// Generic simple dual port RAM with one write port and a registered read port.
// Standalone; sized by its WIDTH and DEPTH parameters.
`default_nettype none
module cmbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[rtl/cmbp_div.sv]
// Restoring divider that produces one quotient bit per cycle.
// Depends on cmbp_pkg for its widths.
`default_nettype none
module cmbp_div import cmbp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [DIV_W-1:0]  dividend,
  input  wire logic [DIVR_W-1:0] divisor,
  output logic                   done,
  output logic      [DIV_W-1:0]  quotient
);
  logic [DIVR_W-1:0]    rem;
  logic [DIVR_W-1:0]    dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 active;
  logic [DIVR_W:0]      trial;
  logic [DIVR_W:0]      diff;

  always_comb begin
    trial = {rem, quotient[DIV_W-1]};
    diff  = trial - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active   <= 1'b1;
        cnt      <= DIV_CNT_W'(DIV_W);
        rem      <= '0;
        dvs      <= divisor;
        quotient <= dividend;
      end else if (active) begin
        if (!diff[DIVR_W]) begin
          rem      <= diff[DIVR_W-1:0];
          quotient <= {quotient[DIV_W-2:0], 1'b1};
        end else begin
          rem      <= trial[DIVR_W-1:0];
          quotient <= {quotient[DIV_W-2:0], 1'b0};
        end
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

[dv/testbench.sv]
// Self-checking testbench for context_match_byte_predictor_core.
// Drives directed and random bytes and window settings, predicts each result in place.
// Depends on cmbp_pkg and the core RTL only.
module testbench;
  import cmbp_pkg::*;

  localparam int LIMIT = 3000000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  literal;
    logic [25:0] probability;
  } word_t;

  typedef struct {
    bit          do_cfg;
    logic [13:0] win;
    logic [7:0]  b;
    bit          typed;
    logic [1:0]  k;
    logic [7:0]  lit;
    logic [25:0] prob;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  byte_in;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  kind;
  logic [7:0]  literal;
  logic [25:0] probability;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [13:0] window_length;

  word_t       expected_words[$];
  int          err_count;
  int          cycle_count;
  int          idle_pct;
  int          stall_pct;

  logic [7:0]  hist_mem [HIST_DEPTH];
  int unsigned hist_head;
  int unsigned byte_pos;
  int unsigned win_len;

  context_match_byte_predictor_core DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .byte_in(byte_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .literal(literal), .probability(probability),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .window_length(window_length)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] byte_back(int unsigned back);
    return hist_mem[(hist_head + HIST_DEPTH - (back % HIST_DEPTH)) % HIST_DEPTH];
  endfunction

  function automatic word_t predict_word(logic [7:0] cur);
    word_t       w;
    int unsigned win;
    int unsigned n;
    int unsigned lv;
    longint unsigned ctx_cnt [LEVELS];
    longint unsigned hit_cnt [LEVELS];
    longint unsigned sum;
    longint unsigned weight;
    w = '0;
    if (byte_pos == 0) begin
      w.kind = KIND_FIRST;
      w.literal = cur;
    end else begin
      win = (win_len > MAX_WINDOW) ? MAX_WINDOW : win_len;
      n = (byte_pos < win) ? byte_pos : win;
      for (int i = 0; i < LEVELS; i++) begin
        ctx_cnt[i] = 0;
        hit_cnt[i] = 0;
      end
      for (int unsigned d = 1; d <= n; d++) begin
        lv = CONTEXT_BYTES;
        for (int unsigned k = 1; k <= CONTEXT_BYTES; k++) begin
          if (byte_back(d + k) != byte_back(k)) begin
            lv = k - 1;
            break;
          end
        end
        ctx_cnt[lv]++;
        if (byte_back(d) == cur) hit_cnt[lv]++;
      end
      sum = 0;
      weight = 0;
      for (int i = 0; i < LEVELS; i++) begin
        if (ctx_cnt[i] != 0) begin
          weight += 64'd1 << i;
          sum += (hit_cnt[i] << (i + 32)) / ctx_cnt[i];
        end
      end
      if (sum == 0) begin
        w.kind = KIND_NEW;
        w.literal = cur;
      end else begin
        w.kind = KIND_REF;
        w.probability = 26'(sum / (weight << (32 - PROB_BITS)));
      end
    end
    hist_mem[hist_head] = cur;
    hist_head = (hist_head + 1) % HIST_DEPTH;
    if (byte_pos != 32'hFFFF_FFFF) byte_pos++;
    return w;
  endfunction

  task automatic send_byte(logic [7:0] b, bit typed, word_t typed_word);
    word_t w;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    byte_in  <= b;
    do @(posedge clk); while (!in_ready);
    w = predict_word(b);
    expected_words.push_back(typed ? typed_word : w);
    @(negedge clk);
  endtask

  task automatic write_window(logic [13:0] v);
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_valid     <= 1'b1;
    window_length <= v;
    do @(posedge clk); while (!cfg_ready);
    win_len = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word kind=%0d literal=%0d probability=%0d",
                 $time, kind, literal, probability);
        err_count++;
      end else begin
        if (kind !== expected_words[0].kind) begin
          $display("%0t: kind expected %0d actual %0d", $time,
                   expected_words[0].kind, kind);
          err_count++;
        end
        if (literal !== expected_words[0].literal) begin
          $display("%0t: literal expected %0d actual %0d", $time,
                   expected_words[0].literal, literal);
          err_count++;
        end
        if (probability !== expected_words[0].probability) begin
          $display("%0t: probability expected %0d actual %0d", $time,
                   expected_words[0].probability, probability);
          err_count++;
        end
        void'(expected_words.pop_front());
      end
    end
  end

  stim_row_t directed [] = '{
    '{0, 0,     8'h00, 1, KIND_FIRST, 8'h00, 26'd0},
    '{0, 0,     8'h00, 1, KIND_REF,   8'h00, 26'd33554432},
    '{0, 0,     8'hFF, 0, 0, 0, 0},
    '{0, 0,     8'h00, 0, 0, 0, 0},
    '{0, 0,     8'hFF, 0, 0, 0, 0},
    '{0, 0,     8'hAA, 0, 0, 0, 0},
    '{0, 0,     8'h55, 0, 0, 0, 0},
    '{0, 0,     8'h00, 0, 0, 0, 0},
    '{0, 0,     8'hFF, 0, 0, 0, 0},
    '{1, 0,     8'h12, 1, KIND_NEW,   8'h12, 26'd0},
    '{0, 0,     8'hFF, 1, KIND_NEW,   8'hFF, 26'd0},
    '{1, 1,     8'h5A, 0, 0, 0, 0},
    '{0, 0,     8'h5A, 0, 0, 0, 0},
    '{0, 0,     8'h5A, 0, 0, 0, 0},
    '{1, 16383, 8'hFF, 0, 0, 0, 0},
    '{0, 0,     8'hFF, 0, 0, 0, 0},
    '{0, 0,     8'h00, 0, 0, 0, 0},
    '{1, 8192,  8'hAA, 0, 0, 0, 0},
    '{0, 0,     8'h55, 0, 0, 0, 0},
    '{0, 0,     8'hAA, 0, 0, 0, 0},
    '{0, 0,     8'h55, 0, 0, 0, 0}
  };

  initial begin
    word_t      tw;
    logic [7:0] pattern [16];
    int         plen;
    int         idle_set  [4];
    int         stall_set [4];
    idle_set  = '{0, 81, 0, 29};
    stall_set = '{0, 0, 81, 29};
    rst = 1'b1;
    in_valid = 1'b0;
    byte_in = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    window_length = '0;
    err_count = 0;
    cycle_count = 0;
    idle_pct = 0;
    stall_pct = 0;
    for (int i = 0; i < HIST_DEPTH; i++) hist_mem[i] = '0;
    hist_head = 0;
    byte_pos = 0;
    win_len = WIN_RESET;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed[i]) begin
      if (directed[i].do_cfg) write_window(directed[i].win);
      tw.kind = directed[i].k;
      tw.literal = directed[i].lit;
      tw.probability = directed[i].prob;
      send_byte(directed[i].b, directed[i].typed, tw);
    end

    for (int ph = 0; ph < 4; ph++) begin
      case ($urandom_range(3))
        0: write_window(14'd1);
        1: write_window(14'd8192);
        2: write_window(14'd16383);
        default: write_window(14'($urandom_range(200, 2)));
      endcase
      idle_pct  = idle_set[ph];
      stall_pct = stall_set[ph];
      for (int i = 0; i < 25; i++) begin
        if (i % 12 == 0) begin
          plen = $urandom_range(12, 1);
          for (int j = 0; j < 16; j++) pattern[j] = 8'($urandom_range(255));
        end
        if ($urandom_range(9) == 0) send_byte(8'($urandom_range(255)), 0, '0);
        else send_byte(pattern[i % plen], 0, '0);
      end
      if (ph == 0) begin
        idle_pct = 0;
        stall_pct = 0;
      end
    end

    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
